### hw/rtl/modular_exponentiation_defines.svh
// ----------------------------------------------------------------------------
// modular_exponentiation_defines
// Assertion macros shared by the modular exponentiation RTL.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// clocked assertion, disabled during reset
`define MEXP_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define MEXP_ASSERT_IMP(lbl, ante, cons, msg) \
  `MEXP_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define MEXP_ASSERT_NXT(lbl, ante, cons, msg) \
  `MEXP_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

### hw/rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Widths, register map, controller states and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  localparam int MOD_WIDTH = 31;
  localparam int BASE_W    = 32;

  localparam int CFG_DW    = (MOD_WIDTH > 32) ? 64 : 32;
  localparam int ADDR_STEP = CFG_DW / 8;
  localparam int ADDR_LSB  = $clog2(ADDR_STEP);
  localparam int PADDR_W   = ADDR_LSB + 1;

  localparam int CNT_MAX   = (BASE_W > MOD_WIDTH) ? BASE_W : MOD_WIDTH;
  localparam int CNT_W     = $clog2(CNT_MAX);

  typedef logic [MOD_WIDTH-1:0] word_t;
  typedef logic [BASE_W-1:0]    base_t;

  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

  localparam word_t EXP_RESET = word_t'(1);
  localparam word_t MOD_RESET = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SETUP,
    ST_CHECK,
    ST_MUL_ACC,
    ST_SQR_GO,
    ST_MUL_SQR,
    ST_FINISH
  } mexp_state_e;

  typedef struct packed {
    logic load;
    logic red_step;
    logic setup;
    logic mul_start;
    logic mul_sqr;
    logic mul_step;
    logic acc_wr;
    logic sqr_wr;
    logic res_wr;
  } mexp_cmd_t;

  typedef struct packed {
    logic red_last;
    logic mul_last;
    logic k_zero;
    logic k_lsb;
  } mexp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/mexp_if.sv
// ----------------------------------------------------------------------------
// mexp_if
// Valid/ready channels for base words in and power words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_in_if;
  logic                  valid;
  logic                  ready;
  mexp_pkg::base_t       base;

  modport source (output valid, output base, input ready);
  modport sink   (input valid, input base, output ready);
endinterface

interface mexp_out_if;
  logic                  valid;
  logic                  ready;
  mexp_pkg::word_t       power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

`default_nettype wire

### hw/rtl/mexp_regs.sv
// ----------------------------------------------------------------------------
// mexp_regs
// APB-style exponent and modulus registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mexp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mexp_pkg::CFG_DW-1:0]  pwdata,
  output      logic [mexp_pkg::CFG_DW-1:0]  prdata,
  output      mexp_pkg::word_t              exponent_o,
  output      mexp_pkg::word_t              modulus_o
);

  mexp_pkg::word_t exp_q, exp_d;
  mexp_pkg::word_t mod_q, mod_d;
  logic            wr_en;
  logic            sel;

  assign wr_en = psel && penable && pwrite;
  assign sel   = paddr[mexp_pkg::ADDR_LSB];

  always_comb begin
    exp_d = exp_q;
    mod_d = mod_q;
    if (wr_en) begin
      unique case (sel)
        mexp_pkg::REG_EXPONENT: exp_d = pwdata[mexp_pkg::MOD_WIDTH-1:0];
        mexp_pkg::REG_MODULUS:  mod_d = pwdata[mexp_pkg::MOD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= mexp_pkg::EXP_RESET;
      mod_q <= mexp_pkg::MOD_RESET;
    end else begin
      exp_q <= exp_d;
      mod_q <= mod_d;
    end
  end

  always_comb begin
    unique case (sel)
      mexp_pkg::REG_EXPONENT: prdata = mexp_pkg::CFG_DW'(exp_q);
      mexp_pkg::REG_MODULUS:  prdata = mexp_pkg::CFG_DW'(mod_q);
      default:                prdata = '0;
    endcase
  end

  assign exponent_o = exp_q;
  assign modulus_o  = mod_q;

endmodule

`default_nettype wire

### hw/rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer: base reduction, square-and-multiply scan, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  input  wire mexp_pkg::mexp_sts_t sts_i,
  output      mexp_pkg::mexp_cmd_t cmd_o
);

  mexp_pkg::mexp_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  res_ok;

  assign res_ok = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mexp_pkg::ST_IDLE:    if (in_valid_i) state_d = mexp_pkg::ST_REDUCE;
      mexp_pkg::ST_REDUCE:  if (sts_i.red_last) state_d = mexp_pkg::ST_SETUP;
      mexp_pkg::ST_SETUP:   state_d = mexp_pkg::ST_CHECK;
      mexp_pkg::ST_CHECK: begin
        priority if (sts_i.k_zero) state_d = mexp_pkg::ST_FINISH;
        else if (sts_i.k_lsb)      state_d = mexp_pkg::ST_MUL_ACC;
        else                       state_d = mexp_pkg::ST_MUL_SQR;
      end
      mexp_pkg::ST_MUL_ACC: if (sts_i.mul_last) state_d = mexp_pkg::ST_SQR_GO;
      mexp_pkg::ST_SQR_GO:  state_d = mexp_pkg::ST_MUL_SQR;
      mexp_pkg::ST_MUL_SQR: if (sts_i.mul_last) state_d = mexp_pkg::ST_CHECK;
      mexp_pkg::ST_FINISH:  if (res_ok) state_d = mexp_pkg::ST_IDLE;
      default:              state_d = mexp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      mexp_pkg::ST_REDUCE:  cmd_o.red_step = 1'b1;
      mexp_pkg::ST_SETUP:   cmd_o.setup = 1'b1;
      mexp_pkg::ST_CHECK: begin
        cmd_o.mul_start = !sts_i.k_zero;
        cmd_o.mul_sqr   = !sts_i.k_lsb;
      end
      mexp_pkg::ST_MUL_ACC: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.acc_wr   = sts_i.mul_last;
      end
      mexp_pkg::ST_SQR_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sqr   = 1'b1;
      end
      mexp_pkg::ST_MUL_SQR: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.sqr_wr   = sts_i.mul_last;
      end
      mexp_pkg::ST_FINISH:  cmd_o.res_wr = res_ok;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.res_wr) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/mexp_dp.sv
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: bit-serial base reduction and shift-add modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_dp (
  input  wire logic                clk_i,
  input  wire mexp_pkg::mexp_cmd_t cmd_i,
  input  wire mexp_pkg::base_t     base_i,
  input  wire mexp_pkg::word_t     exponent_i,
  input  wire mexp_pkg::word_t     modulus_i,
  output      mexp_pkg::mexp_sts_t sts_o,
  output      mexp_pkg::word_t     power_o
);

  localparam int MW = mexp_pkg::MOD_WIDTH;

  // x, y < m: (x + y) mod m
  function automatic mexp_pkg::word_t add_mod(mexp_pkg::word_t x, mexp_pkg::word_t y,
                                              mexp_pkg::word_t m);
    logic [MW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[MW-1:0];
  endfunction

  // r < m: (2r + b) mod m
  function automatic mexp_pkg::word_t red_bit(mexp_pkg::word_t r, logic b,
                                              mexp_pkg::word_t m);
    logic [MW:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[MW-1:0];
  endfunction

  mexp_pkg::base_t              base_q;
  mexp_pkg::word_t              m_q, k_q, a_q, acc_q, x_q, y_q, r_q, power_q;
  logic [mexp_pkg::CNT_W-1:0]   cnt_q;
  mexp_pkg::word_t              r_mul;

  assign r_mul = y_q[0] ? add_mod(r_q, x_q, m_q) : r_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_i;
      m_q    <= modulus_i;
      k_q    <= exponent_i;
      r_q    <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.red_step) begin
      r_q    <= red_bit(r_q, base_q[mexp_pkg::BASE_W-1], m_q);
      base_q <= base_q << 1;
      cnt_q  <= cnt_q + 1'b1;
    end
    if (cmd_i.setup) begin
      a_q   <= r_q;
      acc_q <= (m_q == mexp_pkg::word_t'(1)) ? '0 : mexp_pkg::word_t'(1);
    end
    if (cmd_i.mul_start) begin
      x_q   <= cmd_i.mul_sqr ? a_q : acc_q;
      y_q   <= a_q;
      r_q   <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.mul_step) begin
      r_q   <= r_mul;
      x_q   <= add_mod(x_q, x_q, m_q);
      y_q   <= y_q >> 1;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.acc_wr) acc_q <= r_mul;
    if (cmd_i.sqr_wr) begin
      a_q <= r_mul;
      k_q <= k_q >> 1;
    end
    if (cmd_i.res_wr) power_q <= (m_q == '0) ? '0 : acc_q;
  end

  assign sts_o.red_last = (cnt_q == mexp_pkg::CNT_W'(mexp_pkg::BASE_W - 1));
  assign sts_o.mul_last = (cnt_q == mexp_pkg::CNT_W'(MW - 1));
  assign sts_o.k_zero   = (k_q == '0);
  assign sts_o.k_lsb    = k_q[0];
  assign power_o        = power_q;

endmodule

`default_nettype wire

### hw/rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Each base word returns base ^ exponent mod modulus. One word is worked on
// at a time: an accept step, a bit-serial reduction of the base, a setup
// step, then for every exponent bit up to the highest set one a check and a
// squaring, plus a start step and a multiply for each set bit, then the
// result handoff. The shared shift-add modular multiplier handles one
// multiplier bit per cycle. The result sits in an output register, so the
// next word is taken while it waits. Exponent and modulus are APB registers
// at 0x0 and 0x4; write them only while the block is idle.
// A zero modulus gives 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mexp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mexp_pkg::CFG_DW-1:0]  pwdata,
  output      logic [mexp_pkg::CFG_DW-1:0]  prdata,
  output      logic                         pready,
  mexp_in_if.sink                           in_i,
  mexp_out_if.source                        out_o
);

  mexp_pkg::word_t     exponent;
  mexp_pkg::word_t     modulus;
  mexp_pkg::mexp_cmd_t cmd;
  mexp_pkg::mexp_sts_t sts;

  assign pready = 1'b1;

  mexp_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .exponent_o (exponent),
    .modulus_o  (modulus)
  );

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mexp_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .base_i     (in_i.base),
    .exponent_i (exponent),
    .modulus_i  (modulus),
    .sts_o      (sts),
    .power_o    (out_o.power)
  );

  `MEXP_ASSERT_NXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "word accepted while busy")
  `MEXP_ASSERT_IMP(a_no_overwrite, cmd.res_wr, !out_o.valid || out_o.ready, "pending result overwritten")
  `MEXP_ASSERT_CLK(a_one_op, $onehot0({cmd.load, cmd.red_step, cmd.setup, cmd.mul_start, cmd.mul_step, cmd.res_wr}), "conflicting datapath commands")

endmodule

`default_nettype wire

### tb/modular_exponentiation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_test
// Self-checking bench for the modular exponentiation block. Base words go in
// on bursty valid/ready traffic while the result side stalls on its own
// pattern. Exponent and modulus are set over APB between phases. Each accepted
// base is paired with an independently computed power, and the returned
// powers are compared in order.
// ----------------------------------------------------------------------------
module modular_exponentiation_test;

  typedef logic [mexp_pkg::CFG_DW-1:0] cfg_t;

  localparam int unsigned     CYCLE_LIMIT   = 10_000_000;
  localparam int              SETTLE_CYCLES = 8;
  localparam mexp_pkg::word_t MOD_MAX       = '1;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [mexp_pkg::PADDR_W-1:0]  paddr;
  logic [mexp_pkg::CFG_DW-1:0]   pwdata;
  logic [mexp_pkg::CFG_DW-1:0]   prdata;
  logic                          pready;

  mexp_in_if  base_ch ();
  mexp_out_if power_ch ();

  modular_exponentiation DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (base_ch),
    .out_o   (power_ch)
  );

  mexp_pkg::word_t exp_cfg;
  mexp_pkg::word_t mod_cfg;
  mexp_pkg::word_t power_q[$];
  int              fail_count;
  int              words_sent;
  int              words_checked;
  int              key_settings;
  int              burst_left;
  int unsigned     cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // left-to-right binary exponentiation; products of two residues fit in 62 bits
  function automatic mexp_pkg::word_t pow_mod(mexp_pkg::base_t b, mexp_pkg::word_t e,
                                              mexp_pkg::word_t m);
    logic [63:0] mm;
    logic [63:0] x;
    logic [63:0] r;
    if (m == '0) return '0;
    mm = {{(64-mexp_pkg::MOD_WIDTH){1'b0}}, m};
    x  = {32'h0, b} % mm;
    r  = 64'd1 % mm;
    for (int i = mexp_pkg::MOD_WIDTH - 1; i >= 0; i--) begin
      r = (r * r) % mm;
      if (e[i]) r = (r * x) % mm;
    end
    return mexp_pkg::word_t'(r);
  endfunction

  function automatic mexp_pkg::word_t rand_word(int bits);
    mexp_pkg::word_t v;
    v = mexp_pkg::word_t'({$urandom, $urandom});
    if (bits < mexp_pkg::MOD_WIDTH) begin
      v = v & ((mexp_pkg::word_t'(1) << bits) - mexp_pkg::word_t'(1));
    end
    v[bits-1] = 1'b1;
    return v;
  endfunction

  function automatic mexp_pkg::base_t pick_base(mexp_pkg::word_t m);
    mexp_pkg::base_t b;
    case ($urandom_range(0, 7))
      0, 1:    b = mexp_pkg::base_t'($urandom_range(0, 255));
      2, 3, 4: b = $urandom;
      5: begin
        b = mexp_pkg::base_t'(m) + mexp_pkg::base_t'($urandom_range(0, 2))
            - mexp_pkg::base_t'(1);
      end
      6: begin
        b = ($urandom_range(0, 1) != 0) ? '1 : mexp_pkg::base_t'($urandom_range(0, 1));
      end
      default: b = mexp_pkg::base_t'(m) * mexp_pkg::base_t'($urandom_range(0, 3));
    endcase
    return b;
  endfunction

  task automatic apb_write(logic idx, logic [mexp_pkg::CFG_DW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {{(mexp_pkg::PADDR_W-1){1'b0}}, idx} << mexp_pkg::ADDR_LSB;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == mexp_pkg::REG_EXPONENT) exp_cfg = mexp_pkg::word_t'(data);
    else                               mod_cfg = mexp_pkg::word_t'(data);
    @(negedge clk_i);
    if (prdata !== cfg_t'(mexp_pkg::word_t'(data))) begin
      $display("%0t: register readback mismatch: expected %0h, actual %0h",
               $time, cfg_t'(mexp_pkg::word_t'(data)), prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    base_ch.valid <= 1'b0;
    while (power_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_keys(logic [mexp_pkg::CFG_DW-1:0] e, logic [mexp_pkg::CFG_DW-1:0] m);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_write(mexp_pkg::REG_EXPONENT, e);
    apb_write(mexp_pkg::REG_MODULUS, m);
    key_settings++;
  endtask

  task automatic send_base(mexp_pkg::base_t b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2100) : $urandom_range(1, 6);
      @(negedge clk_i);
      base_ch.valid <= 1'b0;
      base_ch.base  <= $urandom;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk_i);
    base_ch.valid <= 1'b1;
    base_ch.base  <= b;
    @(posedge clk_i);
    while (!base_ch.ready) @(posedge clk_i);
    power_q.push_back(pow_mod(b, exp_cfg, mod_cfg));
    words_sent++;
  endtask

  // receiver: random ready/stall segments, some long
  initial begin
    int seg;
    int kind;
    power_ch.ready = 1'b0;
    forever begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        seg = $urandom_range(1, 50);
        @(negedge clk_i);
        power_ch.ready <= 1'b1;
      end else if (kind <= 7) begin
        seg = $urandom_range(1, 20);
        @(negedge clk_i);
        power_ch.ready <= 1'b0;
      end else if (kind == 8) begin
        seg = $urandom_range(100, 2500);
        @(negedge clk_i);
        power_ch.ready <= 1'b0;
      end else begin
        seg = $urandom_range(2000, 6000);
        @(negedge clk_i);
        power_ch.ready <= 1'b1;
      end
      repeat (seg - 1) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && power_ch.valid && power_ch.ready) begin
      if (power_q.size() == 0) begin
        $display("%0t: unexpected power word %0d", $time, power_ch.power);
        fail_count++;
      end else begin
        if (power_ch.power !== power_q[0]) begin
          $display("%0t: power mismatch: expected %0d, actual %0d",
                   $time, power_q[0], power_ch.power);
          fail_count++;
        end
        void'(power_q.pop_front());
        words_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d powers outstanding", $time, power_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_reset_keys();
    send_base('0);
    send_base(mexp_pkg::base_t'(1));
    send_base(mexp_pkg::base_t'(MOD_MAX) - mexp_pkg::base_t'(1));
    send_base(mexp_pkg::base_t'(MOD_MAX));
    send_base(mexp_pkg::base_t'(MOD_MAX) + mexp_pkg::base_t'(1));
    send_base('1);
  endtask

  task automatic test_zero_exponent();
    set_keys('0, cfg_t'(rand_word($urandom_range(2, mexp_pkg::MOD_WIDTH))));
    send_base('0);
    send_base(mexp_pkg::base_t'(5));
    send_base('1);
  endtask

  task automatic test_tiny_moduli();
    set_keys(32'd65537, 32'd2);
    send_base('0);
    send_base(mexp_pkg::base_t'(3));
    set_keys('0, 32'd1);
    send_base(mexp_pkg::base_t'(7));
    set_keys(32'd5, 32'd1);
    send_base('1);
    set_keys(32'd3, '0);
    send_base(mexp_pkg::base_t'(123));
  endtask

  task automatic test_full_exponent();
    // bit 31 of both writes lies above the register width
    set_keys('1, '1);
    send_base(mexp_pkg::base_t'(2));
    send_base(mexp_pkg::base_t'(MOD_MAX) - mexp_pkg::base_t'(1));
    send_base($urandom);
    set_keys(32'h8000_0011, 32'h8000_00FB);
    send_base(mexp_pkg::base_t'(250));
    send_base($urandom);
  endtask

  task automatic test_random_keys();
    logic [mexp_pkg::CFG_DW-1:0] e;
    logic [mexp_pkg::CFG_DW-1:0] m;
    int                          n;
    for (int phase = 0; phase < 13; phase++) begin
      case (phase % 6)
        0: begin
          e = 32'd65537;
          m = cfg_t'(rand_word($urandom_range(9, mexp_pkg::MOD_WIDTH)));
        end
        1: begin
          e = cfg_t'(rand_word(mexp_pkg::MOD_WIDTH));
          m = cfg_t'(rand_word($urandom_range(2, mexp_pkg::MOD_WIDTH)));
        end
        2: begin
          e = cfg_t'(rand_word($urandom_range(1, mexp_pkg::MOD_WIDTH)));
          m = cfg_t'(rand_word($urandom_range(2, mexp_pkg::MOD_WIDTH)));
        end
        3: begin
          e = ($urandom_range(0, 1) != 0) ? 32'd3 : 32'd17;
          m = cfg_t'(MOD_MAX);
        end
        4: begin
          e = cfg_t'(rand_word($urandom_range(1, mexp_pkg::MOD_WIDTH)));
          m = ($urandom_range(0, 1) != 0) ? 32'd2 : cfg_t'($urandom_range(2, 255));
        end
        default: begin
          e = cfg_t'(rand_word($urandom_range(1, mexp_pkg::MOD_WIDTH)));
          m = cfg_t'(MOD_MAX);
        end
      endcase
      e[mexp_pkg::CFG_DW-1] = 1'($urandom_range(0, 1));
      m[mexp_pkg::CFG_DW-1] = 1'($urandom_range(0, 1));
      set_keys(e, m);
      n = $urandom_range(18, 24);
      for (int i = 0; i < n; i++) begin
        if (phase == 6 && i == n / 2) hold_until_drained();
        else if ($urandom_range(0, 39) == 0) hold_until_drained();
        // encryption phases carry message bytes only
        if (phase % 6 == 0) send_base(mexp_pkg::base_t'($urandom_range(0, 255)));
        else                send_base(pick_base(mod_cfg));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    base_ch.valid = 1'b0;
    base_ch.base  = '0;
    exp_cfg       = mexp_pkg::EXP_RESET;
    mod_cfg       = mexp_pkg::MOD_RESET;
    fail_count    = 0;
    words_sent    = 0;
    words_checked = 0;
    key_settings  = 1;
    burst_left    = 0;
    cycle_count   = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_keys();
    test_zero_exponent();
    test_tiny_moduli();
    test_full_exponent();
    test_random_keys();

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("%0d base words under %0d key settings, %0d powers checked",
             words_sent, key_settings, words_checked);
    $display("covered zero exponent, moduli 0/1/2/max, full-width exponents, masked writes");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
